[src/isie_pkg.sv]
// ----------------------------------------------------------------------------
// isie_pkg: shared constants for the image sampler
// Fixed-point format, mode codes and configuration register indexes.
// ----------------------------------------------------------------------------
package isie_pkg;

    // fraction bits of the sample coordinate (fixed by the 17-bit port)
    localparam int FRAC_BITS = 8;

    // opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // interpolation modes (code three acts as nearest)
    localparam logic [1:0] IM_NEAREST  = 2'd0;
    localparam logic [1:0] IM_BILINEAR = 2'd1;
    localparam logic [1:0] IM_BICUBIC  = 2'd2;

    // edge fill modes (code three acts as black)
    localparam logic [1:0] EM_BLACK  = 2'd0;
    localparam logic [1:0] EM_CLAMP  = 2'd1;
    localparam logic [1:0] EM_LINEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_INTERP = 2'd2;
    localparam logic [1:0] CFG_EXTRAP = 2'd3;

endpackage

[src/image_sampler_interp_extrap.sv]
// ----------------------------------------------------------------------------
// image_sampler_interp_extrap: RGB frame store with a sampling engine
// Loads pixels and samples them with nearest, bilinear or bicubic filters.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_valid / o_stall; a request is taken when i_valid is
//   high and o_stall is low. i_opcode selects a pixel write or a sample.
//   Every request returns exactly one result on o_valid / i_stall.
//   A write (or a sample outside the image) answers on the next cycle.
//   A sample inside the image walks its neighbor window through the single
//   port pixel memory, four reads per neighbor (edge fill needs up to four
//   pixels), then runs a shared filter unit.
//   The memory port takes one read per cycle during the walk.
//   One request is in flight at a time; o_stall stays high while busy.
//   If the receiver stalls, the result holds in the output register and the
//   block takes no new request until that register can be reloaded.
//   Reset clears control state and loads the register defaults; the pixel
//   memory is not cleared, so only written pixels may be sampled.
//   Configuration writes are taken any cycle and belong in idle periods.
// ----------------------------------------------------------------------------
module image_sampler_interp_extrap #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_write_col,
    input  logic [7:0]  i_write_row,
    input  logic [7:0]  i_write_red,
    input  logic [7:0]  i_write_green,
    input  logic [7:0]  i_write_blue,
    input  logic [16:0] i_sample_x,
    input  logic [16:0] i_sample_y,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_outside
);

    localparam int FB    = isie_pkg::FRAC_BITS;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int EW    = $clog2(MAXD + 1);      // effective size width
    localparam int SW    = EW + 2;                // signed neighbor coordinate
    localparam int LW    = ((EW + FB) > 16) ? (EW + FB) : 16;
    localparam int NW    = 41;                    // cubic accumulator

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_FIN   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    // one axis of a neighbor after edge handling
    typedef struct packed {
        logic signed [SW-1:0] a;    // inner (or only) coordinate
        logic signed [SW-1:0] b;    // edge coordinate
        logic [1:0]           d;    // distance beyond the edge
        logic                 inr;  // inside the image
    } t_axis;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] chan(input logic [23:0] w, input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0:    v = w[23:16];
            2'd1:    v = w[15:8];
            default: v = w[7:0];
        endcase
        return v;
    endfunction

    // b + d*(b-a), saturated to 0..255
    function automatic logic [7:0] lin8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [1:0] d);
        logic signed [11:0] a12, b12, d12, t;
        a12 = $signed({4'b0, a});
        b12 = $signed({4'b0, b});
        d12 = $signed({10'b0, d});
        t   = b12 + d12 * (b12 - a12);
        if (t < 0)
            return 8'd0;
        else if (t > 12'sd255)
            return 8'd255;
        else
            return t[7:0];
    endfunction

    function automatic t_axis axis(input logic signed [SW-1:0] c,
                                   input logic signed [SW-1:0] w,
                                   input logic [1:0] em);
        t_axis o;
        logic  neg, hi;
        neg   = c < 0;
        hi    = c >= w;
        o.inr = !neg && !hi;
        o.a   = c;
        o.b   = c;
        o.d   = 2'd0;
        if (!o.inr) begin
            if (em == isie_pkg::EM_CLAMP) begin
                o.a = neg ? SW'(0) : SW'(w - SW'(1));
                o.b = o.a;
            end else begin
                o.a = neg ? SW'(1) : SW'(w - SW'(2));
                o.b = neg ? SW'(0) : SW'(w - SW'(1));
                o.d = neg ? 2'(-c) : 2'(c + SW'(1) - w);
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [8:0] r_width, r_height;
    logic [1:0] r_interp, r_extrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_interp <= isie_pkg::IM_BILINEAR;
            r_extrap <= isie_pkg::EM_CLAMP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                isie_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                isie_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                isie_pkg::CFG_INTERP: r_interp <= i_cfg_data[1:0];
                isie_pkg::CFG_EXTRAP: r_extrap <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // sizes saturate to 2..MAX
    logic [EW-1:0] eff_w, eff_h;
    always_comb begin
        if (32'(r_width) < 32'd2)                eff_w = EW'(2);
        else if (32'(r_width) > 32'(MAX_WIDTH))  eff_w = EW'(MAX_WIDTH);
        else                                     eff_w = EW'(r_width);
        if (32'(r_height) < 32'd2)               eff_h = EW'(2);
        else if (32'(r_height) > 32'(MAX_HEIGHT)) eff_h = EW'(MAX_HEIGHT);
        else                                     eff_h = EW'(r_height);
    end

    logic im_bil, im_bic;
    assign im_bil = (r_interp == isie_pkg::IM_BILINEAR);
    assign im_bic = (r_interp == isie_pkg::IM_BICUBIC);

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    t_state r_state;
    logic   r_ov;
    logic [7:0] r_red, r_green, r_blue;
    logic   r_out;

    logic out_free, in_acc;
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign in_acc   = i_valid && !o_stall;

    // request decode
    logic          is_write, pt_out;
    logic [LW-1:0] xu, yu, wlim, hlim;
    logic [16:0]   xr, yr;
    logic [8:0]    nx, ny;
    logic          wr_ok;

    always_comb begin
        is_write = (i_opcode == isie_pkg::OP_WRITE);
        xu   = LW'(i_sample_x[15:0]);
        yu   = LW'(i_sample_y[15:0]);
        wlim = LW'({eff_w, FB'(0)});
        hlim = LW'({eff_h, FB'(0)});
        pt_out = i_sample_x[16] || i_sample_y[16] || (xu >= wlim) || (yu >= hlim);
        xr = 17'(i_sample_x[15:0]) + 17'(1 << (FB - 1));
        yr = 17'(i_sample_y[15:0]) + 17'(1 << (FB - 1));
        nx = 9'(xr[16:FB]);
        ny = 9'(yr[16:FB]);
        if (32'(nx) >= 32'(eff_w)) nx = 9'(eff_w - EW'(1));
        if (32'(ny) >= 32'(eff_h)) ny = 9'(eff_h - EW'(1));
        wr_ok = (32'(i_write_col) < 32'(MAX_WIDTH)) && (32'(i_write_row) < 32'(MAX_HEIGHT));
    end

    // output register loads: immediate answer, or a finished sample
    logic ov_load;
    assign ov_load = (in_acc && (is_write || pt_out)) || ((r_state == S_OUT) && out_free);

    // sample context
    logic signed [SW-1:0] r_bc, r_br;
    logic [FB-1:0]        r_fx, r_fy;
    logic [2*FB-1:0]      r_fx2, r_fy2;
    logic [3*FB-1:0]      r_fx3, r_fy3;
    logic [3:0]           r_n;
    logic [1:0]           r_s;

    // ------------------------------------------------------------------
    // neighbor generation (current r_n, r_s)
    // ------------------------------------------------------------------
    logic [1:0]           ni, nj;
    logic [3:0]           n_last;
    logic signed [SW-1:0] nc, nr, ws, hs, col, row;
    t_axis                ax_c, ax_r;
    logic                 n_black;
    logic [AW-1:0]        rd_addr;

    always_comb begin
        if (im_bic) begin
            ni = r_n[1:0]; nj = r_n[3:2]; n_last = 4'd15;
        end else if (im_bil) begin
            ni = {1'b0, r_n[0]}; nj = {1'b0, r_n[1]}; n_last = 4'd3;
        end else begin
            ni = 2'd0; nj = 2'd0; n_last = 4'd0;
        end
        ws = $signed(SW'(eff_w));
        hs = $signed(SW'(eff_h));
        nc = r_bc + $signed(SW'(ni));
        nr = r_br + $signed(SW'(nj));
        ax_c = axis(nc, ws, r_extrap);
        ax_r = axis(nr, hs, r_extrap);
        n_black = !(ax_c.inr && ax_r.inr) && (r_extrap != isie_pkg::EM_CLAMP)
                  && (r_extrap != isie_pkg::EM_LINEAR);
        col = r_s[0] ? ax_c.b : ax_c.a;
        row = r_s[1] ? ax_r.b : ax_r.a;
        rd_addr = AW'(AW'(row) * AW'(MAX_WIDTH)) + AW'(col);
    end

    // ------------------------------------------------------------------
    // pixel memory, single port, registered read
    // ------------------------------------------------------------------
    logic [23:0]   r_mem [DEPTH];
    logic [23:0]   r_q;
    logic          mem_we;
    logic [AW-1:0] mem_addr, wr_addr;

    assign wr_addr  = AW'(AW'(i_write_row) * AW'(MAX_WIDTH)) + AW'(i_write_col);
    assign mem_we   = in_acc && is_write && wr_ok;
    assign mem_addr = mem_we ? wr_addr : rd_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[mem_addr] <= {i_write_red, i_write_green, i_write_blue};
        r_q <= r_mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // read tags and edge fill
    // ------------------------------------------------------------------
    logic        r_tv, r_tblk;
    logic [1:0]  r_ts, r_ti, r_tj, r_tdc, r_tdr;
    logic [23:0] r_p0, r_ra;
    logic [23:0] r_vals [4][4];
    logic [23:0] cap_lin, cap_fin;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cap_lin[23-8*k -: 8] = lin8(chan(r_p0, 2'(k)), chan(r_q, 2'(k)), r_tdc);
            cap_fin[23-8*k -: 8] = lin8(chan(r_ra, 2'(k)), cap_lin[23-8*k -: 8], r_tdr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else begin
            r_tv <= (r_state == S_RUN);
        end
        r_ts   <= r_s;
        r_ti   <= ni;
        r_tj   <= nj;
        r_tdc  <= ax_c.d;
        r_tdr  <= ax_r.d;
        r_tblk <= n_black;
        if (r_tv) begin
            case (r_ts) inside
                2'd0, 2'd2: r_p0 <= r_q;
                2'd1:       r_ra <= cap_lin;
                default:    r_vals[r_tj][r_ti] <= r_tblk ? 24'd0 : cap_fin;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // filter unit
    // ------------------------------------------------------------------
    logic [1:0]  r_k;
    logic [2:0]  r_j;
    logic        r_ph;
    logic [16:0] r_h0, r_h1;
    logic [23:0] r_rows [4];
    logic [23:0] r_res;
    logic [7:0]  r_p0c;
    logic signed [18:0] r_pr1;
    logic signed [29:0] r_pr2;
    logic signed [37:0] r_pr3;

    logic [7:0]  ba, bb, bc, bd, bl_v, cu_v;
    logic signed [18:0] h0, h1;
    logic signed [26:0] bv;
    logic [7:0]  pm, p0, p1, p2;
    logic [FB-1:0]   cf;
    logic [2*FB-1:0] cf2;
    logic [3*FB-1:0] cf3;
    logic signed [9:0]  c1;
    logic signed [12:0] c2, c3, em, e0, e1, e2;
    logic signed [NW-1:0] cn;

    always_comb begin
        // bilinear
        ba = chan(r_vals[0][0], r_k);
        bb = chan(r_vals[0][1], r_k);
        bc = chan(r_vals[1][0], r_k);
        bd = chan(r_vals[1][1], r_k);
        h0 = $signed({3'b0, ba, 8'b0})
             + $signed({1'b0, r_fx}) * ($signed({1'b0, bb}) - $signed({1'b0, ba}));
        h1 = $signed({3'b0, bc, 8'b0})
             + $signed({1'b0, r_fx}) * ($signed({1'b0, bd}) - $signed({1'b0, bc}));
        bv = $signed({2'b0, r_h0, 8'b0})
             + $signed({1'b0, r_fy}) * ($signed({1'b0, r_h1}) - $signed({1'b0, r_h0}))
             + 27'sd32768;
        if (bv < 0)                bl_v = 8'd0;
        else if (bv[26:24] != 3'd0) bl_v = 8'd255;
        else                        bl_v = bv[23:16];

        // bicubic taps: a stored row, or the four row results
        if (r_j == 3'd4) begin
            pm = chan(r_rows[0], r_k); p0 = chan(r_rows[1], r_k);
            p1 = chan(r_rows[2], r_k); p2 = chan(r_rows[3], r_k);
            cf = r_fy; cf2 = r_fy2; cf3 = r_fy3;
        end else begin
            pm = chan(r_vals[r_j[1:0]][0], r_k); p0 = chan(r_vals[r_j[1:0]][1], r_k);
            p1 = chan(r_vals[r_j[1:0]][2], r_k); p2 = chan(r_vals[r_j[1:0]][3], r_k);
            cf = r_fx; cf2 = r_fx2; cf3 = r_fx3;
        end
        em = $signed({5'b0, pm});
        e0 = $signed({5'b0, p0});
        e1 = $signed({5'b0, p1});
        e2 = $signed({5'b0, p2});
        c1 = $signed({2'b0, p1}) - $signed({2'b0, pm});
        c2 = 13'sd2 * em - 13'sd5 * e0 + 13'sd4 * e1 - e2;
        c3 = -em + 13'sd3 * e0 - 13'sd3 * e1 + e2;

        cn = (NW'($signed({1'b0, r_p0c})) <<< (3 * FB + 1))
             + (NW'(r_pr1) <<< (2 * FB)) + (NW'(r_pr2) <<< FB) + NW'(r_pr3);
        if (cn < 0)
            cu_v = 8'd0;
        else if ((cn >>> (3 * FB + 1)) > NW'(255))
            cu_v = 8'd255;
        else
            cu_v = cn[3*FB+8 -: 8];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_fx2 <= r_fx * r_fx;
        r_fx3 <= r_fx2 * r_fx;
        r_fy2 <= r_fy * r_fy;
        r_fy3 <= r_fy2 * r_fy;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_n     <= '0;
            r_s     <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_ph    <= 1'b0;
        end else begin
            if (ov_load)
                r_ov <= 1'b1;
            else if (!i_stall)
                r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (is_write || pt_out) begin
                            r_red   <= 8'd0;
                            r_green <= 8'd0;
                            r_blue  <= 8'd0;
                            r_out   <= !is_write;
                        end else begin
                            r_fx <= i_sample_x[FB-1:0];
                            r_fy <= i_sample_y[FB-1:0];
                            if (im_bic) begin
                                r_bc <= $signed(SW'(i_sample_x[15:FB])) - SW'(1);
                                r_br <= $signed(SW'(i_sample_y[15:FB])) - SW'(1);
                            end else if (im_bil) begin
                                r_bc <= $signed(SW'(i_sample_x[15:FB]));
                                r_br <= $signed(SW'(i_sample_y[15:FB]));
                            end else begin
                                r_bc <= $signed(SW'(nx));
                                r_br <= $signed(SW'(ny));
                            end
                            r_n     <= '0;
                            r_s     <= '0;
                            r_k     <= '0;
                            r_j     <= '0;
                            r_ph    <= 1'b0;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_s <= r_s + 2'd1;
                    if (r_s == 2'd3) begin
                        if (r_n == n_last)
                            r_state <= S_DRAIN;
                        else
                            r_n <= r_n + 4'd1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (im_bil) begin
                        if (!r_ph) begin
                            r_h0 <= h0[16:0];
                            r_h1 <= h1[16:0];
                            r_ph <= 1'b1;
                        end else begin
                            case (r_k)
                                2'd0:    r_res[23:16] <= bl_v;
                                2'd1:    r_res[15:8]  <= bl_v;
                                default: r_res[7:0]   <= bl_v;
                            endcase
                            r_ph <= 1'b0;
                            if (r_k == 2'd2) r_state <= S_OUT;
                            else             r_k <= r_k + 2'd1;
                        end
                    end else if (im_bic) begin
                        if (!r_ph) begin
                            r_p0c <= p0;
                            r_pr1 <= c1 * $signed({1'b0, cf});
                            r_pr2 <= c2 * $signed({1'b0, cf2});
                            r_pr3 <= c3 * $signed({1'b0, cf3});
                            r_ph  <= 1'b1;
                        end else begin
                            r_ph <= 1'b0;
                            if (r_j == 3'd4) begin
                                case (r_k)
                                    2'd0:    r_res[23:16] <= cu_v;
                                    2'd1:    r_res[15:8]  <= cu_v;
                                    default: r_res[7:0]   <= cu_v;
                                endcase
                                r_j <= 3'd0;
                                if (r_k == 2'd2) r_state <= S_OUT;
                                else             r_k <= r_k + 2'd1;
                            end else begin
                                case (r_k)
                                    2'd0:    r_rows[r_j[1:0]][23:16] <= cu_v;
                                    2'd1:    r_rows[r_j[1:0]][15:8]  <= cu_v;
                                    default: r_rows[r_j[1:0]][7:0]   <= cu_v;
                                endcase
                                r_j <= r_j + 3'd1;
                            end
                        end
                    end else begin
                        r_res   <= r_vals[0][0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_red   <= r_res[23:16];
                        r_green <= r_res[15:8];
                        r_blue  <= r_res[7:0];
                        r_out   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid   = r_ov;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_outside = r_out;

endmodule

[dv/image_sampler_interp_extrap_tb.sv]
// ----------------------------------------------------------------------------
// image_sampler_interp_extrap_tb: self-checking bench for the image sampler
// Loads pixel windows and samples them under many size, filter and edge-fill
// settings. A scoreboard class models the frame store and predicts each result.
// ----------------------------------------------------------------------------
module image_sampler_interp_extrap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM        = 256;
    localparam int STALL_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int PHASES      = 11;
    localparam int RAND_PER_PHASE = 51;

    typedef struct {
        logic               op;
        logic [7:0]         col, row, red, green, blue;
        logic signed [16:0] sx, sy;
    } t_request;

    typedef struct {
        logic [7:0] red, green, blue;
        logic       outside;
    } t_pixel_result;

    typedef struct { int ch[3]; } t_rgb;

    // ------------------------------------------------------------------------
    // Frame model and expected-result store
    // ------------------------------------------------------------------------
    class SamplerScoreboard;
        logic [23:0]     frame[DIM*DIM];
        bit              written[DIM*DIM];
        int              img_w, img_h;
        logic [1:0]      interp, edge_fill;
        bit              unwritten_hit;
        t_pixel_result   due[$];
        int              errors, requests, samples, outside_cnt;

        function new();
            img_w = DIM; img_h = DIM;
            interp = isie_pkg::IM_BILINEAR; edge_fill = isie_pkg::EM_CLAMP;
        endfunction

        function void configure(int w, int h, logic [1:0] im, logic [1:0] em);
            img_w = (w < 2) ? 2 : ((w > DIM) ? DIM : w);
            img_h = (h < 2) ? 2 : ((h > DIM) ? DIM : h);
            interp = im;
            edge_fill = em;
        endfunction

        function int sat8(longint v);
            return (v < 0) ? 0 : ((v > 255) ? 255 : int'(v));
        endfunction

        function t_rgb fetch(int c, int r);
            t_rgb p;
            int   a;
            p.ch = '{0, 0, 0};
            if (c >= 0 && c < DIM && r >= 0 && r < DIM) begin
                a = r * DIM + c;
                if (!written[a]) unwritten_hit = 1;
                p.ch[0] = frame[a][23:16];
                p.ch[1] = frame[a][15:8];
                p.ch[2] = frame[a][7:0];
            end
            return p;
        endfunction

        function t_rgb lin(t_rgb a, t_rgb b, int d);
            t_rgb o;
            for (int k = 0; k < 3; k++)
                o.ch[k] = sat8(longint'(b.ch[k]) + longint'(d) * (b.ch[k] - a.ch[k]));
            return o;
        endfunction

        // neighbor value with edge fill applied
        function t_rgb neighbor(int c, int r);
            bit   cin, rin;
            int   ic, ec, dc, ir, er, dr;
            t_rgb z;
            cin = c >= 0 && c < img_w;
            rin = r >= 0 && r < img_h;
            z.ch = '{0, 0, 0};
            if (cin && rin) return fetch(c, r);
            if (edge_fill == isie_pkg::EM_CLAMP)
                return fetch(c < 0 ? 0 : (c >= img_w ? img_w - 1 : c),
                             r < 0 ? 0 : (r >= img_h ? img_h - 1 : r));
            if (edge_fill != isie_pkg::EM_LINEAR) return z;
            ic = c < 0 ? 1 : img_w - 2; ec = c < 0 ? 0 : img_w - 1;
            dc = c < 0 ? -c : 1 + c - img_w;
            ir = r < 0 ? 1 : img_h - 2; er = r < 0 ? 0 : img_h - 1;
            dr = r < 0 ? -r : 1 + r - img_h;
            if (rin) return lin(fetch(ic, r), fetch(ec, r), dc);
            if (cin) return lin(fetch(c, ir), fetch(c, er), dr);
            // corner: horizontal on both edge rows, then vertical
            return lin(lin(fetch(ic, ir), fetch(ec, ir), dc),
                       lin(fetch(ic, er), fetch(ec, er), dc), dr);
        endfunction

        function int catmull(longint f, int pm, int p0, int p1, int p2);
            longint one, n;
            one = 256;
            n = longint'(2 * p0) * one * one * one
              + longint'(p1 - pm) * f * one * one
              + longint'(2 * pm - 5 * p0 + 4 * p1 - p2) * f * f * one
              + longint'(-pm + 3 * p0 - 3 * p1 + p2) * f * f * f;
            if (n < 0) return 0;
            return sat8(n >>> 25);
        endfunction

        function t_pixel_result predict(t_request q);
            t_pixel_result res;
            longint        x, y, fx, fy, h0, h1, v;
            int            ix, iy, nx, ny;
            t_rgb          g[4][4], a, b, c, d, px;
            int            rows[4];
            res = '{8'd0, 8'd0, 8'd0, 1'b0};
            if (q.op == isie_pkg::OP_WRITE) return res;
            x = longint'(q.sx);
            y = longint'(q.sy);
            if (x < 0 || y < 0 || x >= img_w * 256 || y >= img_h * 256) begin
                res.outside = 1'b1;
                return res;
            end
            ix = int'(x >>> 8); fx = x & 255;
            iy = int'(y >>> 8); fy = y & 255;
            if (interp == isie_pkg::IM_BILINEAR) begin
                a = neighbor(ix, iy);     b = neighbor(ix + 1, iy);
                c = neighbor(ix, iy + 1); d = neighbor(ix + 1, iy + 1);
                for (int k = 0; k < 3; k++) begin
                    h0 = (256 - fx) * a.ch[k] + fx * b.ch[k];
                    h1 = (256 - fx) * c.ch[k] + fx * d.ch[k];
                    v  = (256 - fy) * h0 + fy * h1 + 32768;
                    px.ch[k] = sat8(v >>> 16);
                end
            end else if (interp == isie_pkg::IM_BICUBIC) begin
                for (int j = 0; j < 4; j++)
                    for (int i = 0; i < 4; i++)
                        g[j][i] = neighbor(ix - 1 + i, iy - 1 + j);
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 4; j++)
                        rows[j] = catmull(fx, g[j][0].ch[k], g[j][1].ch[k],
                                          g[j][2].ch[k], g[j][3].ch[k]);
                    px.ch[k] = catmull(fy, rows[0], rows[1], rows[2], rows[3]);
                end
            end else begin
                // nearest, also for the unused mode code
                nx = int'((x + 128) >>> 8);
                ny = int'((y + 128) >>> 8);
                if (nx >= img_w) nx = img_w - 1;
                if (ny >= img_h) ny = img_h - 1;
                px = fetch(nx, ny);
            end
            res.red = px.ch[0]; res.green = px.ch[1]; res.blue = px.ch[2];
            return res;
        endfunction

        // true when the request reads only pixels already written
        function bit is_safe(t_request q);
            t_pixel_result r;
            unwritten_hit = 0;
            r = predict(q);
            return !unwritten_hit;
        endfunction

        function void note_request(t_request q);
            t_pixel_result r;
            r = predict(q);
            due.push_back(r);
            requests++;
            if (q.op == isie_pkg::OP_WRITE) begin
                frame[int'(q.row) * DIM + int'(q.col)] = {q.red, q.green, q.blue};
                written[int'(q.row) * DIM + int'(q.col)] = 1;
            end else begin
                samples++;
                if (r.outside) outside_cnt++;
            end
        endfunction

        function void check_result(t_pixel_result got);
            t_pixel_result want;
            if (due.size() == 0) begin
                $display("%0t: result with nothing pending: rgb %h %h %h outside %b",
                         $time, got.red, got.green, got.blue, got.outside);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red mismatch, expected %h actual %h",
                         $time, want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green mismatch, expected %h actual %h",
                         $time, want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue mismatch, expected %h actual %h",
                         $time, want.blue, got.blue);
                errors++;
            end
            if (got.outside !== want.outside) begin
                $display("%0t: outside mismatch, expected %b actual %b",
                         $time, want.outside, got.outside);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        i_clk = 0, i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = '0;
    logic [8:0]  i_cfg_data = '0;
    logic        i_valid = 0, o_stall;
    logic        i_opcode = 0;
    logic [7:0]  i_write_col = '0, i_write_row = '0;
    logic [7:0]  i_write_red = '0, i_write_green = '0, i_write_blue = '0;
    logic [16:0] i_sample_x = '0, i_sample_y = '0;
    logic        o_valid, i_stall = 0;
    logic [7:0]  o_red, o_green, o_blue;
    logic        o_outside;

    image_sampler_interp_extrap DUT (.*);

    SamplerScoreboard sb = new();
    int scheme = 0;         // 0: dense sender/busy receiver, 1: reverse, 2: no idling
    int idle_cycles = 0;

    initial forever #5 i_clk = ~i_clk;

    // result side: check, randomize stall, and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_red, o_green, o_blue, o_outside});
        i_stall <= (scheme == 2) ? 1'b0 :
                   ($urandom_range(99) < ((scheme == 0) ? 82 : 21));
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("image_sampler_interp_extrap_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------------
    // Valid stays high across back-to-back requests; it only drops for a gap or a drain.
    task automatic send(t_request q);
        int gap;
        gap = 0;
        if (scheme != 2)
            while ($urandom_range(99) < ((scheme == 0) ? 21 : 82) && gap < 40) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= q.op;
        i_write_col   <= q.col;   i_write_row   <= q.row;
        i_write_red   <= q.red;   i_write_green <= q.green;
        i_write_blue  <= q.blue;
        i_sample_x    <= q.sx;    i_sample_y    <= q.sy;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(q);
    endtask

    // drop valid and let every pending result come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(int w, int h, logic [1:0] im, logic [1:0] em);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= isie_pkg::CFG_WIDTH;  i_cfg_data <= w[8:0];  @(posedge i_clk);
        i_cfg_idx <= isie_pkg::CFG_HEIGHT; i_cfg_data <= h[8:0];  @(posedge i_clk);
        i_cfg_idx <= isie_pkg::CFG_INTERP; i_cfg_data <= {7'd0, im}; @(posedge i_clk);
        i_cfg_idx <= isie_pkg::CFG_EXTRAP; i_cfg_data <= {7'd0, em}; @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.configure(w, h, im, em);
    endtask

    // channel value biased toward the extremes so edge fill saturates
    function automatic logic [7:0] chan();
        int k;
        k = $urandom_range(9);
        return (k == 0) ? 8'h00 : ((k == 1) ? 8'hFF : 8'($urandom_range(255)));
    endfunction

    function automatic t_request pixel_write(int c, int r);
        t_request q;
        q.op = isie_pkg::OP_WRITE; q.col = c[7:0]; q.row = r[7:0];
        q.red = chan(); q.green = chan(); q.blue = chan();
        q.sx = 17'($urandom); q.sy = 17'($urandom);   // don't-care on writes
        return q;
    endfunction

    function automatic t_request sample_at(int x, int y);
        t_request q;
        q = pixel_write($urandom_range(255), $urandom_range(255));
        q.op = isie_pkg::OP_SAMPLE;
        q.sx = x[16:0]; q.sy = y[16:0];
        return q;
    endfunction

    task automatic fill_block(int c0, int r0, int nw, int nh);
        for (int r = r0; r < r0 + nh; r++)
            for (int c = c0; c < c0 + nw; c++)
                send(pixel_write(c, r));
    endtask

    // a sample mostly inside the written window; retried until it only
    // touches written pixels
    function automatic t_request pick_sample(int ox, int oy, int nw, int nh);
        t_request q;
        int       kind, x, y;
        for (int t = 0; t < 40; t++) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                x = $urandom_range(ox * 256, (ox + nw) * 256 - 1);
                y = $urandom_range(oy * 256, (oy + nh) * 256 - 1);
            end else if (kind < 80) begin
                // integer or nearly-next positions
                x = $urandom_range(ox, ox + nw - 1) * 256 + ($urandom_range(1) ? 0 : 255);
                y = $urandom_range(oy, oy + nh - 1) * 256 + ($urandom_range(1) ? 0 : 255);
            end else begin
                x = $signed(17'($urandom));
                y = $signed(17'($urandom));
            end
            q = sample_at(x, y);
            if (sb.is_safe(q)) return q;
        end
        return sample_at(-1, $urandom_range(1000));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    int         ph_w[PHASES]  = '{256, 2, 5, 4, 8, 511, 12, 0, 256, 7, 3};
    int         ph_h[PHASES]  = '{256, 2, 3, 7, 8, 1, 10, 256, 256, 5, 9};
    logic [1:0] ph_im[PHASES] = '{isie_pkg::IM_BILINEAR, isie_pkg::IM_NEAREST,
                                  isie_pkg::IM_BILINEAR, isie_pkg::IM_BICUBIC,
                                  isie_pkg::IM_BICUBIC, 2'd3, isie_pkg::IM_BICUBIC,
                                  isie_pkg::IM_BILINEAR, isie_pkg::IM_BICUBIC,
                                  isie_pkg::IM_NEAREST, 2'd3};
    logic [1:0] ph_em[PHASES] = '{isie_pkg::EM_CLAMP, isie_pkg::EM_BLACK,
                                  isie_pkg::EM_LINEAR, isie_pkg::EM_LINEAR,
                                  isie_pkg::EM_CLAMP, 2'd3, isie_pkg::EM_BLACK,
                                  isie_pkg::EM_LINEAR, isie_pkg::EM_LINEAR,
                                  isie_pkg::EM_CLAMP, isie_pkg::EM_LINEAR};

    initial begin
        int ox, oy, nw, nh;
        int dx[10] = '{0, 128, 383, -1, 0, -65536, 65535, 65535, 1280, 640};
        int dy[10] = '{0, 128, 1, 0, -1, -65536, 65535, 0, 1279, 65535};
        t_request q;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            scheme = (p < 4) ? 0 : ((p < 8) ? 1 : 2);
            // phase 0 runs on the reset defaults
            if (p != 0) set_config(ph_w[p], ph_h[p], ph_im[p], ph_em[p]);
            nw = (sb.img_w < 6) ? sb.img_w : 6;
            nh = (sb.img_h < 6) ? sb.img_h : 6;
            if (sb.img_w * sb.img_h <= 64) begin
                ox = 0; oy = 0; nw = sb.img_w; nh = sb.img_h;
            end else begin
                // window at a corner or somewhere inside
                ox = $urandom_range(2) == 0 ? 0 :
                     ($urandom_range(1) ? sb.img_w - nw : $urandom_range(sb.img_w - nw));
                oy = $urandom_range(2) == 0 ? 0 :
                     ($urandom_range(1) ? sb.img_h - nh : $urandom_range(sb.img_h - nh));
            end
            fill_block(ox, oy, nw, nh);

            if (p == 0) begin
                // directed: opposite corners, boundaries, coordinate extremes
                fill_block(0, 0, 6, 6);
                fill_block(250, 250, 6, 6);
                q = pixel_write(0, 0);
                {q.red, q.green, q.blue} = 24'h000000;
                send(q);
                q = pixel_write(255, 255);
                {q.red, q.green, q.blue} = 24'hFFFFFF;
                send(q);
                for (int i = 0; i < 10; i++) begin
                    q = sample_at(dx[i], dy[i]);
                    if (sb.is_safe(q)) send(q);
                end
            end

            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                if (p == 5 && i == RAND_PER_PHASE / 2) drain();   // sender holds off
                if ($urandom_range(99) < 25) begin
                    if ($urandom_range(4) == 0)
                        send(pixel_write($urandom_range(255), $urandom_range(255)));
                    else
                        send(pixel_write(ox + $urandom_range(nw - 1),
                                         oy + $urandom_range(nh - 1)));
                end else begin
                    send(pick_sample(ox, oy, nw, nh));
                end
            end
            drain();
            repeat (4) @(posedge i_clk);
        end

        repeat (30) @(posedge i_clk);
        $display("Ran %0d requests (%0d samples, %0d outside) across %0d settings",
                 sb.requests, sb.samples, sb.outside_cnt, PHASES);
        $display("covering all filters, edge fills, clamped sizes and both idle mixes");
        if (sb.errors == 0 && sb.due.size() == 0) begin
            $display("image_sampler_interp_extrap_tb OK");
        end else begin
            $display("image_sampler_interp_extrap_tb NOT OK");
        end
        $finish;
    end

endmodule
